// File: rtl/psr_pkg.sv
// Package for the pitch snap ratio unit: item structs, register indexes,
// note and sine tables. Used by psr_div and pitch_snap_ratio_unit.
package psr_pkg;

  localparam int NoteCount   = 120;
  localparam int SineEntries = 256;
  localparam int SineBits    = $clog2(SineEntries);

  // Divider widths: numerator is (31-bit value << 14) plus half the divisor.
  localparam int NumW  = 46;
  localparam int DenW  = 30;
  localparam int QuotW = 17;
  localparam int CntW  = $clog2(NumW + 1);

  localparam logic [2:0] RegSnapMode     = 3'd0;
  localparam logic [2:0] RegScaleMask    = 3'd1;
  localparam logic [2:0] RegAttackBlocks = 3'd2;
  localparam logic [2:0] RegVibPhaseStep = 3'd3;
  localparam logic [2:0] RegVibDepth     = 3'd4;

  typedef struct packed {
    logic [21:0] detected_freq;
    logic [21:0] target_freq;
    logic [12:0] frames;
  } in_item_t;

  typedef struct packed {
    logic [15:0] shift_ratio;
    logic [22:0] shifted_freq;
    logic [6:0]  snapped_note;
  } out_item_t;

  // Octave zero of the note table, Q.16 Hz.
  localparam logic [19:0] Oct0Q16 [12] = '{
    20'd535757, 20'd567615, 20'd601367, 20'd637126, 20'd675011, 20'd715150,
    20'd757675, 20'd802728, 20'd850461, 20'd901032, 20'd954610, 20'd1011374
  };

  typedef logic signed [15:0] sine_tab_t [SineEntries];

  // Quarter-wave polynomial sine, Q1.14, evaluated at elaboration only.
  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [31:0] turn;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    for (int j = 0; j < SineEntries; j++) begin
      turn = 32'((64'(j) << 32) / SineEntries);
      x    = 64'(turn[29:14]);
      if (turn[30]) begin
        x = 64'd65536 - x;
      end
      x2 = (x * x) >> 16;
      t  = 64'd5223 - ((x2 * 64'd307) >> 16);
      t  = 64'd42334 - ((x2 * t) >> 16);
      t  = 64'd102944 - ((x2 * t) >> 16);
      t  = (x * t) >> 16;
      t  = (t + 64'd2) >> 2;
      if (t > 64'd16384) begin
        t = 64'd16384;
      end
      tab[j] = turn[31] ? -$signed(16'(t)) : $signed(16'(t));
    end
    return tab;
  endfunction

  localparam sine_tab_t SineTab = build_sine();

endpackage

// File: rtl/psr_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on psr_pkg for its widths.
module psr_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [psr_pkg::NumW-1:0]  num_i,
  input  logic [psr_pkg::DenW-1:0]  den_i,
  output logic                      done_o,
  output logic [psr_pkg::QuotW-1:0] quot_o,
  output logic                      ovf_o
);
  import psr_pkg::*;

  logic [NumW-1:0]  num_q;
  logic [DenW-1:0]  den_q;
  logic [DenW-1:0]  rem_q;
  logic [QuotW-1:0] quot_q;
  logic             ovf_q;
  logic [CntW-1:0]  cnt_q;
  logic             done_q;
  logic [DenW:0]    trial;
  logic             ge;

  assign trial = {rem_q, num_q[NumW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CntW'(NumW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
      ovf_q  <= 1'b0;
    end else if (cnt_q != '0) begin
      num_q  <= {num_q[NumW-2:0], 1'b0};
      rem_q  <= ge ? DenW'(trial - {1'b0, den_q}) : DenW'(trial);
      quot_q <= {quot_q[QuotW-2:0], ge};
      ovf_q  <= ovf_q | quot_q[QuotW-1];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign ovf_o  = ovf_q;

endmodule

// File: rtl/pitch_snap_ratio_unit.sv
// Top level of the pitch snap ratio unit: note search, glide, vibrato and
// ratio output. Depends on psr_pkg and psr_div.
//
// One input transfer carries a detected pitch, a target pitch and the block
// length; one output transfer returns the shift ratio, the shifted pitch and
// the note being targeted. Both channels use a valid/ready handshake.
// In snap mode the block walks the note table one note per cycle (up to
// note NoteCount-1), picks the nearer note, runs the bit-serial divider,
// then the vibrato states StVibA to StVibC and the clamping and output
// scaling states StFin and StOut; with no allowed note it skips the
// divider. Target mode skips the walk and vibrato, and an unvoiced pitch
// goes straight to clamping and output.
// One item is processed at a time; a finished result sits in an output
// register, so a new item is taken while the receiver stalls, and only the
// next result waits for that register to empty.
// Reset clears the note, glide count and vibrato phase and loads the
// register defaults. The user must write registers over the APB port only
// while the block is idle; the block itself does not enforce this.
module pitch_snap_ratio_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  psr_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output psr_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import psr_pkg::*;

  typedef enum logic [11:0] {
    StIdle   = 12'b000000000001,
    StSearch = 12'b000000000010,
    StDecide = 12'b000000000100,
    StPrep1  = 12'b000000001000,
    StPrep2  = 12'b000000010000,
    StPrep3  = 12'b000000100000,
    StDiv    = 12'b000001000000,
    StVibA   = 12'b000010000000,
    StVibB   = 12'b000100000000,
    StVibC   = 12'b001000000000,
    StFin    = 12'b010000000000,
    StOut    = 12'b100000000000
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic        snap_q;
  logic [11:0] mask_q;
  logic [7:0]  attack_q;
  logic [23:0] step_q;
  logic [10:0] depth_q;

  // Persistent state.
  logic [6:0]  cur_note_q;
  logic [7:0]  glide_q;
  logic [31:0] phase_q;

  // Item working registers.
  logic [21:0] f_q;
  logic [12:0] frames_q;
  logic [6:0]  i_q;
  logic [3:0]  pc_q;
  logic [3:0]  oct_q;
  logic [21:0] lo_q, hi_q, n_q;
  logic [6:0]  lo_i_q, hi_i_q;
  logic        lo_v_q, hi_v_q;
  logic [7:0]  e_q;
  logic        gliding_q;
  logic [30:0] num_q;
  logic [DenW-1:0]  den_q;
  logic [QuotW-1:0] base_q;
  logic             base_ovf_q;
  logic signed [15:0] sine_q;
  logic signed [13:0] vib_q;
  logic [15:0] ratio_q;
  logic        out_valid_q;
  out_item_t   out_q;

  logic wr_en;
  logic accept;
  logic [29:0] note_shift;
  logic [21:0] note_f;
  logic        note_ok;
  logic        last_note;
  logic signed [22:0] d_hi, d_lo;
  logic        pick_lo;
  logic [21:0] pick_f;
  logic [6:0]  pick_i;
  logic [7:0]  e_new;
  logic [NumW-1:0]  div_num;
  logic             div_start, div_done, div_ovf;
  logic [QuotW-1:0] div_quot;
  logic signed [27:0] prod;
  logic signed [18:0] total;
  logic [38:0] sf_full;
  logic        out_free;

  // Configuration port.
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_q   <= 1'b0;
      mask_q   <= 12'd2741;
      attack_q <= 8'd0;
      step_q   <= 24'd389567;
      depth_q  <= 11'd0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        RegSnapMode:     snap_q   <= pwdata[0];
        RegScaleMask:    mask_q   <= pwdata[11:0];
        RegAttackBlocks: attack_q <= pwdata[7:0];
        RegVibPhaseStep: step_q   <= pwdata[23:0];
        RegVibDepth:     depth_q  <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      RegSnapMode:     prdata = {31'd0, snap_q};
      RegScaleMask:    prdata = {20'd0, mask_q};
      RegAttackBlocks: prdata = {24'd0, attack_q};
      RegVibPhaseStep: prdata = {8'd0, step_q};
      RegVibDepth:     prdata = {21'd0, depth_q};
      default:         prdata = 32'd0;
    endcase
  end

  // Handshake.
  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Frequency of the note under the search pointer, rounded to Q.8.
  assign note_shift = 30'(Oct0Q16[pc_q]) << oct_q;
  assign note_f     = 22'((note_shift + 30'd128) >> 8);
  assign note_ok    = mask_q[pc_q];
  assign last_note  = (i_q == 7'(NoteCount - 1));

  // The lower note wins only when it is strictly nearer.
  assign d_hi    = $signed({1'b0, hi_q}) - $signed({1'b0, f_q});
  assign d_lo    = $signed({1'b0, f_q}) - $signed({1'b0, lo_q});
  assign pick_lo = lo_v_q && (d_hi > d_lo);
  assign pick_f  = pick_lo ? lo_q : hi_q;
  assign pick_i  = pick_lo ? lo_i_q : hi_i_q;
  assign e_new   = (pick_i != cur_note_q) ? 8'd0 : glide_q;

  assign div_start = (state_q == StPrep3);
  assign div_num   = {1'b0, num_q, 14'd0} + NumW'(den_q >> 1);

  psr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .ovf_o   (div_ovf)
  );

  assign prod  = sine_q * $signed({1'b0, depth_q});
  assign total = $signed({2'b00, (base_ovf_q ? {QuotW{1'b1}} : base_q)}) + vib_q;
  assign sf_full = 39'(f_q) * 39'(ratio_q) + 39'd8192;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cur_note_q  <= '0;
      glide_q     <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // A result is loaded whenever the output register is free; otherwise
      // a transfer on the output side empties it.
      if (state_q == StOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            if (snap_q && in_data_i.detected_freq != '0) begin
              state_q <= StSearch;
            end else if (!snap_q && in_data_i.detected_freq != '0 &&
                         in_data_i.target_freq != '0) begin
              state_q <= StPrep3;
            end else begin
              state_q <= StFin;
            end
          end
        end
        StSearch: begin
          if ((note_ok && note_f > f_q) || last_note) begin
            state_q <= StDecide;
          end
        end
        StDecide: begin
          if (hi_v_q) begin
            cur_note_q <= pick_i;
            glide_q    <= (e_new == 8'd255) ? 8'd255 : e_new + 8'd1;
            state_q    <= StPrep1;
          end else begin
            state_q <= StVibA;
          end
        end
        StPrep1: state_q <= StPrep2;
        StPrep2: state_q <= StPrep3;
        StPrep3: state_q <= StDiv;
        StDiv: begin
          if (div_done) begin
            state_q <= snap_q ? StVibA : StFin;
          end
        end
        StVibA: begin
          phase_q <= phase_q + 32'(step_q) * 32'(frames_q);
          state_q <= StVibB;
        end
        StVibB: state_q <= StVibC;
        StVibC: state_q <= StFin;
        StFin:  state_q <= StOut;
        StOut: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        f_q        <= in_data_i.detected_freq;
        frames_q   <= in_data_i.frames;
        i_q        <= 7'd1;
        pc_q       <= 4'd1;
        oct_q      <= 4'd0;
        lo_v_q     <= 1'b0;
        hi_v_q     <= 1'b0;
        lo_q       <= '0;
        hi_q       <= '0;
        lo_i_q     <= '0;
        hi_i_q     <= '0;
        vib_q      <= '0;
        base_q     <= QuotW'(16384);
        base_ovf_q <= 1'b0;
        num_q      <= 31'(in_data_i.target_freq);
        den_q      <= DenW'(in_data_i.detected_freq);
      end
      StSearch: begin
        if (note_ok) begin
          lo_q   <= hi_q;
          lo_i_q <= hi_i_q;
          lo_v_q <= hi_v_q;
          hi_q   <= note_f;
          hi_i_q <= i_q;
          hi_v_q <= 1'b1;
        end
        i_q <= i_q + 7'd1;
        if (pc_q == 4'd11) begin
          pc_q  <= 4'd0;
          oct_q <= oct_q + 4'd1;
        end else begin
          pc_q <= pc_q + 4'd1;
        end
      end
      StDecide: begin
        n_q       <= pick_f;
        e_q       <= e_new;
        gliding_q <= attack_q > e_new;
      end
      StPrep1: begin
        if (gliding_q) begin
          num_q <= 31'(f_q) * 31'(attack_q - e_q);
          den_q <= DenW'(f_q) * DenW'(attack_q);
        end else begin
          num_q <= 31'(n_q);
          den_q <= DenW'(f_q);
        end
      end
      StPrep2: begin
        if (gliding_q) begin
          num_q <= num_q + 31'(n_q) * 31'(e_q);
        end
      end
      StDiv: begin
        if (div_done) begin
          base_q     <= div_quot;
          base_ovf_q <= div_ovf;
        end
      end
      StVibB: sine_q <= SineTab[phase_q[31 -: SineBits]];
      StVibC: vib_q  <= 14'((prod + 28'sd8192) >>> 14);
      StFin: begin
        if (total > 19'sd32768) begin
          ratio_q <= 16'd32768;
        end else if (total < 19'sd8192) begin
          ratio_q <= 16'd8192;
        end else begin
          ratio_q <= 16'(total);
        end
      end
      StOut: begin
        if (out_free) begin
          out_q.shift_ratio  <= ratio_q;
          out_q.shifted_freq <= (sf_full[38:14] > 25'h7FFFFF) ? 23'h7FFFFF
                                                               : sf_full[36:14];
          out_q.snapped_note <= cur_note_q;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: verif/pitch_snap_ratio_unit_tb.sv
// Testbench for pitch_snap_ratio_unit: directed and random pitch items under
// several register settings, checked against an in-bench predictor.
// Depends on psr_pkg and the RTL of the pitch snap ratio unit.
`timescale 1ns / 1ps

module pitch_snap_ratio_unit_tb;
  import psr_pkg::*;

  localparam int WatchdogCycles = 20000;
  localparam int Notes          = 120;
  localparam int ExpectDepth    = 1024;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pitch_snap_ratio_unit i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // The predictor keeps its own copy of the registers and the block state.
  logic        cfg_snap;
  logic [11:0] cfg_mask;
  logic [7:0]  cfg_attack;
  logic [23:0] cfg_step;
  logic [10:0] cfg_depth;
  logic [6:0]  held_note;
  logic [7:0]  glide_blocks;
  logic [31:0] vib_turn;

  int         sine_lut [256];
  out_item_t  expect_fifo [ExpectDepth];
  int         exp_wr_idx = 0;
  int         exp_rd_idx = 0;
  bit         failed = 1'b0;
  bit         quiet = 1'b0;   // no idling on either side while set
  int         stall_left = 0;
  int         idle_cycles = 0;

  const logic [19:0] octave_zero [12] = '{
    20'd535757, 20'd567615, 20'd601367, 20'd637126, 20'd675011, 20'd715150,
    20'd757675, 20'd802728, 20'd850461, 20'd901032, 20'd954610, 20'd1011374
  };

  function automatic longint note_hz(int i);
    longint v;
    v = longint'(octave_zero[i % 12]) << (i / 12);
    return (v + 128) >>> 8;
  endfunction

  // Quarter-wave polynomial sine in Q1.14, clamped to full scale.
  function automatic int sine_at(logic [31:0] turn);
    longint x, x2, t;
    x = longint'(turn[29:14]);
    if (turn[30]) begin
      x = 65536 - x;
    end
    x2 = (x * x) >>> 16;
    t  = 5223 - ((x2 * 307) >>> 16);
    t  = 42334 - ((x2 * t) >>> 16);
    t  = 102944 - ((x2 * t) >>> 16);
    t  = (x * t) >>> 16;
    t  = (t + 2) >>> 2;
    if (t > 16384) begin
      t = 16384;
    end
    return turn[31] ? -int'(t) : int'(t);
  endfunction

  function automatic longint div_half_up(longint num, longint den);
    return (num + den / 2) / den;
  endfunction

  // Works out the result of one pitch item and advances the held state.
  function automatic out_item_t predict_shift(in_item_t it);
    longint    f, tg, ratio, lo, hi, n, a, e, prod, sf;
    int        lo_i, hi_i, n_i;
    bit        lo_v, hi_v;
    out_item_t res;
    f     = longint'(it.detected_freq);
    tg    = longint'(it.target_freq);
    ratio = 16384;
    lo = 0; hi = 0; lo_i = 0; hi_i = 0; lo_v = 0; hi_v = 0;
    if (cfg_snap) begin
      if (f > 0) begin
        for (int i = 1; i < Notes; i++) begin
          if (cfg_mask[i % 12]) begin
            lo = hi; lo_i = hi_i; lo_v = hi_v;
            hi = note_hz(i); hi_i = i; hi_v = 1'b1;
            if (hi > f) begin
              break;
            end
          end
        end
        if (hi_v) begin
          n = hi; n_i = hi_i;
          // The lower note wins only when strictly nearer; a tie goes up.
          if (lo_v && (hi - f) > (f - lo)) begin
            n = lo; n_i = lo_i;
          end
          if (n_i != held_note) begin
            glide_blocks = '0;
            held_note    = 7'(n_i);
          end
          if (cfg_attack > glide_blocks) begin
            a = longint'(cfg_attack);
            e = longint'(glide_blocks);
            ratio = div_half_up((f * (a - e) + n * e) * 16384, f * a);
          end else begin
            ratio = div_half_up(n * 16384, f);
          end
          if (glide_blocks != 8'hff) begin
            glide_blocks++;
          end
        end
        vib_turn = vib_turn + 32'(longint'(cfg_step) * longint'(it.frames));
        prod  = longint'(sine_lut[vib_turn[31:24]]) * longint'(cfg_depth);
        ratio = ratio + ((prod + 8192) >>> 14);
      end
    end else if (f > 0 && tg > 0) begin
      ratio = div_half_up(tg * 16384, f);
    end
    if (ratio > 32768) ratio = 32768;
    if (ratio < 8192)  ratio = 8192;
    sf = (f * ratio + 8192) >>> 14;
    if (sf > 64'h7fffff) sf = 64'h7fffff;
    res.shift_ratio  = 16'(ratio);
    res.shifted_freq = 23'(sf);
    res.snapped_note = held_note;
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 120);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 2'b00}; pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      RegSnapMode:     cfg_snap   = value[0];
      RegScaleMask:    cfg_mask   = value[11:0];
      RegAttackBlocks: cfg_attack = value[7:0];
      RegVibPhaseStep: cfg_step   = value[23:0];
      RegVibDepth:     cfg_depth  = value[10:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic snap, logic [11:0] mask, logic [7:0] attack,
                         logic [23:0] step, logic [10:0] depth);
    write_reg(RegSnapMode, 32'(snap));
    write_reg(RegScaleMask, 32'(mask));
    write_reg(RegAttackBlocks, 32'(attack));
    write_reg(RegVibPhaseStep, 32'(step));
    write_reg(RegVibDepth, 32'(depth));
  endtask

  // Valid is held from one transfer to the next when no gap is drawn.
  task automatic send_item(logic [21:0] det, logic [21:0] tgt, logic [12:0] frames);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    in_data_i  = '{detected_freq: det, target_freq: tgt, frames: frames};
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expect_fifo[exp_wr_idx % ExpectDepth] = predict_shift(in_data_i);
    exp_wr_idx++;
  endtask

  // Lets every outstanding result arrive before registers are touched.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (exp_wr_idx != exp_rd_idx) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // Pitch in a musical range most of the time, anywhere in the field otherwise.
  function automatic logic [21:0] rand_pitch();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 80) return 22'($urandom_range(20 * 256, 4000 * 256));
    if (r < 90) return 22'($urandom_range(1, 20 * 256));
    return 22'($urandom);
  endfunction

  function automatic logic [12:0] rand_frames();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 13'($urandom_range(64, 1024));
    if (r < 95) return 13'($urandom_range(1, 4096));
    return 13'($urandom);
  endfunction

  task automatic test_target_mode();
    set_all(1'b0, 12'd2741, 8'd0, 24'd389567, 11'd0);
    send_item(22'd0, 22'd0, 13'd1);
    send_item(22'd0, 22'h3fffff, 13'd4096);
    send_item(22'h3fffff, 22'd0, 13'd1);
    send_item(22'h3fffff, 22'h3fffff, 13'd100);
    send_item(22'h3fffff, 22'd1, 13'd100);      // clamps at one half
    send_item(22'd1, 22'h3fffff, 13'd100);      // clamps at two
    send_item(22'd112640, 22'd168960, 13'd512);
    send_item(22'h2aaaaa, 22'h155555, 13'h1fff);
    drain();
  endtask

  task automatic test_snap_directed();
    longint lo, hi;
    int     pair;
    set_all(1'b1, 12'hfff, 8'd0, 24'd389567, 11'd0);
    send_item(22'd0, 22'd5, 13'd256);           // unvoiced: ratio stays one
    send_item(22'd1, 22'd0, 13'd256);           // far below the lowest note
    send_item(22'h3fffff, 22'd0, 13'd256);      // above the highest note
    send_item(22'd112640, 22'd0, 13'd256);
    // A pitch exactly between two allowed notes must take the upper one.
    pair = 40;
    while (((note_hz(pair) + note_hz(pair + 1)) % 2) != 0) pair++;
    lo = note_hz(pair);
    hi = note_hz(pair + 1);
    send_item(22'((lo + hi) / 2), 22'd0, 13'd256);
    send_item(22'((lo + hi) / 2 - 1), 22'd0, 13'd256);
    drain();
    write_reg(RegScaleMask, 32'd0);             // no note allowed
    write_reg(RegVibDepth, 32'd1024);
    send_item(22'd112640, 22'd0, 13'd4096);
    send_item(22'd50000, 22'd0, 13'd1);
    drain();
    // A note change starts the glide; steady pitch lets it run out.
    set_all(1'b1, 12'd2741, 8'd4, 24'hffffff, 11'd0);
    repeat (6) send_item(22'd113000, 22'd0, 13'd128);
    repeat (3) send_item(22'd60000, 22'd0, 13'd128);
    drain();
  endtask

  task automatic test_random();
    logic [11:0] mask;
    logic [7:0]  attack;
    logic [10:0] depth;
    logic [21:0] pitch;
    int          run;
    for (int ph = 0; ph < 8; ph++) begin
      quiet = (ph == 3);
      case (ph)
        0: begin mask = 12'hfff; attack = 8'd0;   depth = 11'd0; end
        1: begin mask = 12'h001; attack = 8'd255; depth = 11'd1024; end
        2: begin mask = 12'h800; attack = 8'd1;   depth = 11'h7ff; end
        default: begin
          mask   = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom);
          attack = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 8)) : 8'($urandom);
          depth  = 11'($urandom_range(0, 1100));
        end
      endcase
      set_all(ph != 7, mask, attack,
              (ph == 1) ? 24'hffffff : (ph == 0) ? 24'd0 : 24'($urandom), depth);
      run = 0;
      while (run < 90) begin
        // Held pitches keep the same note so glides run their course.
        pitch = rand_pitch();
        repeat ($urandom_range(1, 6)) begin
          send_item(pitch + 22'($urandom_range(0, 64)),
                    ($urandom_range(0, 19) == 0) ? 22'd0 : rand_pitch(),
                    rand_frames());
          run++;
        end
      end
      drain();
    end
    quiet = 1'b0;
  endtask

  // Receiver side: random stalls, with none while the quiet flag is set.
  always @(negedge clk_i) begin
    if (!rst_ni || stall_left > 0) begin
      out_ready_i <= 1'b0;
      if (stall_left > 0) stall_left <= stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 5) == 0) stall_left <= pick_gap();
    end
  end

  // Each result transfer is checked against the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (exp_wr_idx == exp_rd_idx) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        failed = 1'b1;
      end else begin
        want = expect_fifo[exp_rd_idx % ExpectDepth];
        exp_rd_idx++;
        if (out_data_o.shift_ratio !== want.shift_ratio) begin
          $display("%0t: shift_ratio expected %0d got %0d",
                   $time, want.shift_ratio, out_data_o.shift_ratio);
          failed = 1'b1;
        end
        if (out_data_o.shifted_freq !== want.shifted_freq) begin
          $display("%0t: shifted_freq expected %0d got %0d",
                   $time, want.shifted_freq, out_data_o.shifted_freq);
          failed = 1'b1;
        end
        if (out_data_o.snapped_note !== want.snapped_note) begin
          $display("%0t: snapped_note expected %0d got %0d",
                   $time, want.snapped_note, out_data_o.snapped_note);
          failed = 1'b1;
        end
      end
    end
  end

  // Ends the run if no transfer happens on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogCycles) begin
      $display("** pitch_snap_ratio_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int j = 0; j < 256; j++) begin
      sine_lut[j] = sine_at(32'(j) << 24);
    end
    cfg_snap = 1'b0; cfg_mask = 12'd2741; cfg_attack = '0;
    cfg_step = 24'd389567; cfg_depth = '0;
    held_note = '0; glide_blocks = '0; vib_turn = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // The default registers are exercised before anything is written.
    send_item(22'd112640, 22'd56320, 13'd1);
    drain();
    test_target_mode();
    test_snap_directed();
    test_random();
    repeat (200) @(negedge clk_i);
    if (!failed && exp_wr_idx == exp_rd_idx) begin
      $display("** pitch_snap_ratio_unit: PASSED **");
    end else begin
      $display("** pitch_snap_ratio_unit: FAILED **");
    end
    $finish;
  end

endmodule

// File: pitch_snap_ratio_unit.f
rtl/psr_pkg.sv
rtl/psr_div.sv
rtl/pitch_snap_ratio_unit.sv
verif/pitch_snap_ratio_unit_tb.sv
